>>> rtl/lruk_pkg.sv
// Shared types and constants for the LRU-K frame replacer.
// Used by the controller, the datapath and the top level.
package lruk_pkg;

  localparam int NUM_FRAMES = 16;
  localparam int K_MAX      = 8;

  localparam logic [1:0] OP_REGISTER = 2'd0;
  localparam logic [1:0] OP_ACCESS   = 2'd1;
  localparam logic [1:0] OP_SET      = 2'd2;
  localparam logic [1:0] OP_EVICT    = 2'd3;

  typedef struct packed {
    logic exec;
    logic scan_start;
    logic scan_step;
    logic finish;
  } lruk_cmd_t;

  typedef struct packed {
    logic is_evict;
    logic scan_last;
  } lruk_stat_t;

endpackage

>>> rtl/lruk_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lruk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/lruk_ctrl.sv
// Controller state machine for the LRU-K frame replacer.
// Depends on lruk_pkg; drives the datapath by command and status.
module lruk_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  lruk_pkg::lruk_stat_t stat,
  output lruk_pkg::lruk_cmd_t  cmd
);
  import lruk_pkg::*;

  typedef enum logic [1:0] {IDLE, SCAN, DRAIN, DONE} state_t;
  state_t state;

  logic take;
  logic out_valid_next;
  assign in_ready = (state == IDLE) && (!out_valid || out_ready);
  assign take = in_valid && in_ready;

  always_comb begin
    cmd = '0;
    cmd.exec       = take && !stat.is_evict;
    cmd.scan_start = take && stat.is_evict;
    cmd.scan_step  = (state == SCAN);
    cmd.finish     = (state == DRAIN);
  end

  always_comb begin
    out_valid_next = out_valid && !out_ready;
    if ((state == IDLE) && take && !stat.is_evict) out_valid_next = 1'b1;
    if (state == DRAIN) out_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      case (state)
        IDLE: begin
          if (take && stat.is_evict) state <= SCAN;
        end
        SCAN: begin
          if (stat.scan_last) state <= DRAIN;
        end
        DRAIN: begin
          state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) (state != IDLE) |-> !in_ready)
    else $error("input accepted while busy");
  assert property (@(posedge clk) disable iff (rst) (state == DRAIN) |=> out_valid)
    else $error("evict result not presented");
  assert property (@(posedge clk) disable iff (rst) (state == SCAN) |-> !out_valid)
    else $error("stale result during scan");

endmodule

>>> rtl/lruk_dp.sv
// Datapath for the LRU-K frame replacer: frame marks, histories, stamp RAM
// and the serial evict comparator. Depends on lruk_pkg and lruk_ram.
module lruk_dp #(
  parameter int STAMP_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  lruk_pkg::lruk_cmd_t  cmd,
  output lruk_pkg::lruk_stat_t stat,
  input  logic                 cfg_we,
  input  logic [3:0]           cfg_data,
  input  logic [1:0]           opcode,
  input  logic [3:0]           frame_index,
  input  logic                 evictable_flag,
  output logic                 victim_found,
  output logic [3:0]           victim_frame,
  output logic [4:0]           evictable_count,
  output logic                 ignored
);
  import lruk_pkg::*;

  localparam int FW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int KW = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam int LW = $clog2(K_MAX + 1);
  localparam int AW = $clog2(NUM_FRAMES * K_MAX) > 0 ? $clog2(NUM_FRAMES * K_MAX) : 1;
  localparam int CW = $clog2(NUM_FRAMES + 1);
  localparam logic [STAMP_BITS-1:0] STAMP_MAX = '1;

  logic [NUM_FRAMES-1:0] reg_mark, evi_mark;
  logic [LW-1:0] hist_len  [NUM_FRAMES];
  logic [KW-1:0] hist_head [NUM_FRAMES];
  logic [STAMP_BITS-1:0] access_clock;
  logic [CW-1:0] evi_total;
  logic [3:0] k_value;

  logic [LW-1:0] eff_k;
  always_comb begin
    if (k_value == 4'd0) eff_k = LW'(1);
    else if (32'(k_value) > K_MAX) eff_k = LW'(K_MAX);
    else eff_k = LW'(k_value);
  end

  // current-item decode
  logic [FW-1:0] fi;
  logic in_range, known;
  assign fi       = FW'(frame_index);
  assign in_range = 32'(frame_index) < NUM_FRAMES;
  assign known    = in_range && reg_mark[fi];
  assign stat.is_evict = (opcode == OP_EVICT);

  // access arithmetic
  logic [LW-1:0] a_len, a_keep;
  logic [KW-1:0] a_head, a_slot;
  always_comb begin
    a_len  = hist_len[fi];
    a_head = hist_head[fi];
    a_keep = a_len;
    if (a_len >= eff_k) begin
      a_keep = eff_k - LW'(1);
      a_head = KW'((32'(hist_head[fi]) + 32'(a_len) - 32'(a_keep)) % K_MAX);
    end
    a_slot = KW'((32'(a_head) + 32'(a_keep)) % K_MAX);
  end

  logic ram_we;
  logic [AW-1:0] waddr, raddr;
  logic [STAMP_BITS-1:0] rdata;
  assign ram_we = cmd.exec && (opcode == OP_ACCESS) && known;
  assign waddr  = AW'(32'(fi) * K_MAX + 32'(a_slot));

  // scan: issue frame sidx, compare it in the cycle after
  logic [FW:0] sidx;
  logic [FW-1:0] cidx;
  logic cvalid;
  logic [LW-1:0] r_len, rpos;
  logic [KW-1:0] rslot;
  logic [FW-1:0] sf;
  assign sf = sidx[FW-1:0];
  always_comb begin
    rpos  = (hist_len[sf] < eff_k) ? '0 : hist_len[sf] - eff_k;
    rslot = KW'((32'(hist_head[sf]) + 32'(rpos)) % K_MAX);
  end
  assign raddr = AW'(32'(sf) * K_MAX + 32'(rslot));
  assign stat.scan_last = cvalid && (32'(cidx) == NUM_FRAMES - 1);

  lruk_ram #(.WIDTH(STAMP_BITS), .DEPTH(NUM_FRAMES * K_MAX)) u_ram (
    .clk(clk), .we(ram_we), .waddr(waddr), .wdata(access_clock),
    .raddr(raddr), .rdata(rdata)
  );

  logic have, best_short, done_empty;
  logic [STAMP_BITS-1:0] best_key;
  logic [FW-1:0] best;
  logic c_elig, c_short, c_take;
  assign r_len   = hist_len[cidx];
  assign c_elig  = cvalid && reg_mark[cidx] && evi_mark[cidx] && !done_empty;
  assign c_short = r_len < eff_k;
  assign c_take  = c_elig && ((r_len == '0) || !have || (c_short && !best_short) ||
                   (c_short == best_short && rdata < best_key));

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_mark     <= '0;
      evi_mark     <= '0;
      access_clock <= '0;
      evi_total    <= '0;
      k_value      <= 4'd2;
      cvalid       <= 1'b0;
      sidx         <= '0;
      for (int i = 0; i < NUM_FRAMES; i++) begin
        hist_len[i]  <= '0;
        hist_head[i] <= '0;
      end
    end else begin
      if (cfg_we) k_value <= cfg_data;
      cvalid <= cmd.scan_step && (32'(sidx) < NUM_FRAMES);
      if (cmd.exec) begin
        victim_found <= 1'b0;
        victim_frame <= '0;
        ignored      <= ((opcode == OP_ACCESS) || (opcode == OP_SET)) && !known;
        case (opcode)
          OP_REGISTER: begin
            if (in_range && !reg_mark[fi]) begin
              reg_mark[fi]  <= 1'b1;
              evi_mark[fi]  <= 1'b1;
              hist_len[fi]  <= '0;
              hist_head[fi] <= '0;
              evi_total     <= evi_total + CW'(1);
            end
          end
          OP_ACCESS: begin
            if (known) begin
              hist_head[fi] <= a_head;
              hist_len[fi]  <= a_keep + LW'(1);
              if (access_clock != STAMP_MAX) access_clock <= access_clock + 1'b1;
            end
          end
          OP_SET: begin
            if (known && evictable_flag && !evi_mark[fi]) begin
              evi_mark[fi] <= 1'b1;
              evi_total    <= evi_total + CW'(1);
            end else if (known && !evictable_flag && evi_mark[fi]) begin
              evi_mark[fi] <= 1'b0;
              evi_total    <= evi_total - CW'(1);
            end
          end
          default: ;
        endcase
      end
      if (cmd.scan_start) begin
        sidx <= '0;
        have <= 1'b0;
        done_empty <= 1'b0;
        best <= '0;
        best_short <= 1'b0;
        best_key <= '0;
      end
      if (cmd.scan_step) begin
        if (32'(sidx) < NUM_FRAMES) begin
          cidx   <= sf;
          sidx   <= sidx + 1'b1;
        end
        if (c_take) begin
          have       <= 1'b1;
          best       <= cidx;
          best_short <= c_short;
          best_key   <= rdata;
          if (r_len == '0) done_empty <= 1'b1;
        end
      end
      if (cmd.finish) begin
        victim_found <= have;
        victim_frame <= have ? 4'(best) : 4'd0;
        ignored      <= 1'b0;
        if (have) begin
          hist_len[best]  <= '0;
          hist_head[best] <= '0;
        end
      end
    end
  end

  assign evictable_count = (32'(evi_total) > 31) ? 5'd31 : 5'(evi_total);

  assert property (@(posedge clk) disable iff (rst) 32'(evi_total) <= NUM_FRAMES)
    else $error("evictable total overflow");
  assert property (@(posedge clk) disable iff (rst) c_take |-> reg_mark[cidx] && evi_mark[cidx])
    else $error("ineligible frame chosen");
  assert property (@(posedge clk) disable iff (rst) ram_we |-> !cmd.scan_step)
    else $error("stamp write during scan");

endmodule

>>> rtl/lru_k_frame_replacer_unit.sv
// Top level of the LRU-K frame replacer.
// Depends on lruk_pkg, lruk_ctrl, lruk_dp and lruk_ram.
//
// Requests arrive on the in channel (opcode, frame_index, evictable_flag),
// one result beat leaves on the out channel for every request.
// Register, access and set evictable results are
// registered in the cycle after acceptance.
// Evict scans every frame through one comparator reading the stamp RAM,
// then passes through DRAIN before the result is presented.
// One request is in flight at a time; in_ready drops while a request is
// being worked on or while a result waits and the receiver stalls.
// k_value is written by cfg_we/cfg_data; write it only while idle (not enforced by the block).
// Reset clears all marks, histories, the access clock and the evictable
// count, and sets k_value to 2. Stamp RAM contents are never cleared;
// only stamps in slots written by access decide the victim.
module lru_k_frame_replacer_unit #(
  parameter int STAMP_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [3:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] opcode,
  input  logic [3:0] frame_index,
  input  logic       evictable_flag,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       victim_found,
  output logic [3:0] victim_frame,
  output logic [4:0] evictable_count,
  output logic       ignored
);
  import lruk_pkg::*;

  lruk_cmd_t  cmd;
  lruk_stat_t stat;

  lruk_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd)
  );

  lruk_dp #(.STAMP_BITS(STAMP_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .opcode(opcode), .frame_index(frame_index), .evictable_flag(evictable_flag),
    .victim_found(victim_found), .victim_frame(victim_frame),
    .evictable_count(evictable_count), .ignored(ignored)
  );

endmodule
